>>> hdl/pmst_pkg.sv
// Package for the Prim spanning tree block: sizes, action codes, sequencer states.
// No dependencies.
package pmst_pkg;
   localparam int MaxVertices = 64;
   localparam int WeightBits  = 16;
   localparam int VtxBits     = $clog2(MaxVertices);
   localparam int CellBits    = 2 * VtxBits;
   localparam int CountBits   = 7;

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_RUN   = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_INIT,
      ST_SEL,
      ST_REL_RD,
      ST_REL,
      ST_EMIT,
      ST_EMIT_WAIT
   } state_type;
endpackage

>>> hdl/prim_minimum_spanning_tree_top.sv
// Prim minimum spanning tree over a dense weight matrix memory; depends on pmst_pkg.
// Requests: edge add, clear and run; a run from an out-of-range start vertex emits n
// records with no parent and does no selection.
// Each selection scans n keys, then relaxes n cells over one read port.
// Requests are taken one at a time; receiver stalls hold the emit phase of a run.
// Reset: synchronous, active high; presence bits of all 4096 cells cleared, vertex_count 64.
module prim_minimum_spanning_tree_top
   import pmst_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write,
   input  logic [CountBits-1:0]         csr_vertex_count,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_action,
   input  logic [5:0]                   req_edge_source,
   input  logic [5:0]                   req_edge_target,
   input  logic signed [WeightBits-1:0] req_edge_cost,
   input  logic [5:0]                   req_start_vertex,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [5:0]                   rsp_tree_parent,
   output logic [5:0]                   rsp_tree_child,
   output logic signed [WeightBits-1:0] rsp_link_cost,
   output logic                         rsp_has_parent,
   output logic                         rsp_last
);
   localparam int Cells = MaxVertices * MaxVertices;

   // Matrix memory: weight and presence in one word.
   logic [WeightBits:0] mat_mem [Cells];
   logic [WeightBits:0] mat_rd_ff;
   logic                mat_we;
   logic [CellBits-1:0] mat_wa, mat_ra;
   logic [WeightBits:0] mat_wd;

   // Vertex memory: parent and key per vertex.
   logic [VtxBits+WeightBits-1:0] node_mem [MaxVertices];
   logic [VtxBits+WeightBits-1:0] node_rd_ff;
   logic                          node_we;
   logic [VtxBits-1:0]            node_wa;
   logic [VtxBits+WeightBits-1:0] node_wd;
   logic signed [WeightBits-1:0]  node_key, mat_cost, best_ff;
   logic [VtxBits-1:0]            node_par;
   logic                          sel_take, relax;

   logic [MaxVertices-1:0]       fin_ff, pv_ff, vis_ff;

   state_type state_ff, state_in;
   logic [CountBits-1:0] cnt_ff;
   logic [CellBits:0]    idx_ff, idx_in;   // sweep / scan counter
   logic [VtxBits-1:0]   u_ff, u_in;
   logic                 found_ff, found_in;
   logic [VtxBits-1:0]   src_ff, dst_ff;
   logic signed [WeightBits-1:0] cost_ff;
   logic [VtxBits-1:0]   root_ff;
   logic [CountBits-1:0] n_ff;

   logic [CountBits-1:0] n_eff;
   always_comb begin
      n_eff = cnt_ff;
      if (cnt_ff == '0) n_eff = CountBits'(1);
      if (cnt_ff > CountBits'(MaxVertices)) n_eff = CountBits'(MaxVertices);
   end

   logic [VtxBits-1:0] w;
   assign w = idx_ff[VtxBits-1:0];
   logic scan_end;
   assign scan_end = ({1'b0, idx_ff[CountBits-1:0]} + 8'd1) >= {1'b0, n_ff};

   assign node_key = node_rd_ff[WeightBits-1:0];
   assign node_par = node_rd_ff[VtxBits+WeightBits-1:WeightBits];
   assign mat_cost = mat_rd_ff[WeightBits-1:0];
   assign sel_take = (state_ff == ST_SEL) && !vis_ff[w] && fin_ff[w] &&
                     (!found_ff || node_key < best_ff);
   assign relax    = (state_ff == ST_REL) && !vis_ff[w] && mat_rd_ff[WeightBits] &&
                     (!fin_ff[w] || mat_cost < node_key);

   always_ff @(posedge clock) begin
      if (mat_we) mat_mem[mat_wa] <= mat_wd;
      mat_rd_ff <= mat_mem[mat_ra];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      u_in     = u_ff;
      found_in = found_ff;
      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (req_valid) begin
               case (action_type'(req_action))
                  ACT_CLEAR: state_in = ST_CLEAR;
                  ACT_ADD:   state_in = ST_ADD_RD;
                  ACT_RUN:   state_in = ST_INIT;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR: begin
            idx_in = idx_ff + 1'b1;
            if (idx_ff[CellBits-1:0] == '1) state_in = ST_IDLE;
         end
         ST_ADD_RD: state_in = ST_ADD_WR;
         ST_ADD_WR: state_in = ST_IDLE;
         ST_INIT: begin
            idx_in = '0; found_in = 1'b0;
            state_in = ({1'b0, root_ff} < n_ff) ? ST_SEL : ST_EMIT;
         end
         ST_SEL: begin
            if (sel_take) begin
               u_in = w; found_in = 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            if (scan_end) begin
               idx_in = '0;
               if (found_in) state_in = ST_REL_RD;
               else state_in = ST_EMIT;
            end
         end
         ST_REL_RD: state_in = ST_REL;
         ST_REL: begin
            idx_in = idx_ff + 1'b1;
            state_in = ST_REL_RD;
            if (scan_end) begin
               idx_in = '0; found_in = 1'b0; state_in = ST_SEL;
            end
         end
         ST_EMIT: state_in = ST_EMIT_WAIT;
         ST_EMIT_WAIT: begin
            if (!rsp_stall) begin
               idx_in = idx_ff + 1'b1;
               state_in = scan_end ? ST_IDLE : ST_EMIT_WAIT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs / datapath controls
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      mat_we = 1'b0;
      mat_wa = {src_ff, dst_ff};
      mat_wd = {1'b1, cost_ff};
      mat_ra = {src_ff, dst_ff};
      node_we = 1'b0;
      node_wa = w;
      node_wd = {u_ff, mat_cost};
      case (state_ff)
         ST_IDLE: begin
            // seed the root key as the run is taken
            if (req_valid && action_type'(req_action) == ACT_RUN) begin
               node_we = 1'b1;
               node_wa = req_start_vertex;
               node_wd = '0;
            end
         end
         ST_CLEAR: begin
            mat_we = 1'b1;
            mat_wa = idx_ff[CellBits-1:0];
            mat_wd = '0;
         end
         ST_ADD_WR: begin
            mat_we = !mat_rd_ff[WeightBits] ||
                     (cost_ff < $signed(mat_rd_ff[WeightBits-1:0]));
         end
         ST_REL_RD: mat_ra = {u_ff, w};
         ST_REL: node_we = relax;
         default: ;
      endcase
      rsp_valid = (state_ff == ST_EMIT_WAIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         idx_ff   <= '0;
         cnt_ff   <= CountBits'(MaxVertices);
         fin_ff   <= '0;
         pv_ff    <= '0;
         vis_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         found_ff <= found_in;
         if (csr_write) cnt_ff <= csr_vertex_count;
         if (state_ff == ST_INIT) begin
            pv_ff <= '0; vis_ff <= '0;
            fin_ff <= ({1'b0, root_ff} < n_ff) ? (MaxVertices'(1) << root_ff) : '0;
         end
         if (state_ff == ST_SEL && scan_end && found_in) vis_ff[u_in] <= 1'b1;
         if (relax) begin
            fin_ff[w] <= 1'b1;
            pv_ff[w]  <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      u_ff <= u_in;
      if (sel_take) best_ff <= node_key;
      if (state_ff == ST_IDLE && req_valid) begin
         src_ff  <= req_edge_source;
         dst_ff  <= req_edge_target;
         cost_ff <= req_edge_cost;
         root_ff <= req_start_vertex;
         n_ff    <= n_eff;
      end
      if (node_we) node_mem[node_wa] <= node_wd;
      // read ahead at the next scan index so the data lines up with w
      node_rd_ff <= node_mem[idx_in[VtxBits-1:0]];
   end

   assign rsp_tree_child  = w;
   assign rsp_has_parent  = pv_ff[w];
   assign rsp_tree_parent = pv_ff[w] ? node_par : '0;
   assign rsp_link_cost   = pv_ff[w] ? node_key : '0;
   assign rsp_last        = scan_end;
endmodule
